>>> rtl/dcp_pkg.sv
`default_nettype none
package dcp_pkg;
   localparam int COORD_WIDTH_DEF = 32;
endpackage
`default_nettype wire

>>> rtl/distance_constraint_projection.sv
// Distance constraint projection, one constraint per request.
// Request channel: req_valid / req_stall carry both endpoint positions, the
// rest length and an active flag. Result channel: rsp_valid / rsp_stall carry
// the corrected positions and a coincident flag, one result per request, in
// order. Coordinates are signed, COORD_WIDTH bits; results saturate.
// The pipeline from acceptance to rsp_valid has three input/square/sum
// stages, one bit of square root per stage over COORD_WIDTH+1 stages, one
// product stage, one quotient bit per stage over COORD_WIDTH+2 stages for
// both axes at once, and one saturation stage.
// Throughput is one request per cycle while rsp_stall does not hold the pipeline.
// When rsp_valid is high and rsp_stall is high, the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
// Synchronous reset clears all valid bits; the data registers are not reset.
`default_nettype none
module distance_constraint_projection import dcp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_WIDTH-1:0] req_first_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_first_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_second_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_second_y,
   input  wire logic        [COORD_WIDTH-2:0] req_rest_length,
   input  wire logic                          req_active,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_first_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_first_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_second_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_second_y,
   output logic                               rsp_coincident
);
   localparam int W  = COORD_WIDTH;
   localparam int SQ = W + 1;
   localparam int SW = 2 * SQ;
   localparam int RW = SQ + 3;
   localparam int QW = W + 2;
   localparam int DW = W + 2;
   localparam int NW = 2 * W + 4;
   localparam int EW = W + 4;

   typedef struct packed {
      logic signed [W-1:0] x1;
      logic signed [W-1:0] y1;
      logic signed [W-1:0] x2;
      logic signed [W-1:0] y2;
      logic [W-2:0]        rest;
      logic                act;
      logic                nx;
      logic                ny;
      logic [W:0]          mx;
      logic [W:0]          my;
   } pay_type;

   logic en;
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // input stage
   logic signed [W:0] dx_in, dy_in;
   pay_type a_in, a_ff;
   logic a_valid_ff;
   always_comb begin
      dx_in = {req_first_x[W-1], req_first_x} - {req_second_x[W-1], req_second_x};
      dy_in = {req_first_y[W-1], req_first_y} - {req_second_y[W-1], req_second_y};
      a_in.x1 = req_first_x;
      a_in.y1 = req_first_y;
      a_in.x2 = req_second_x;
      a_in.y2 = req_second_y;
      a_in.rest = req_rest_length;
      a_in.act = req_active;
      a_in.nx = dx_in[W];
      a_in.ny = dy_in[W];
      a_in.mx = dx_in[W] ? (W+1)'(0) - dx_in : dx_in;
      a_in.my = dy_in[W] ? (W+1)'(0) - dy_in : dy_in;
   end

   // squares and sum
   pay_type b_ff, c_ff;
   logic b_valid_ff, c_valid_ff;
   logic [SW-1:0] sqx_ff, sqy_ff, s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         b_ff   <= a_ff;
         sqx_ff <= a_ff.mx * a_ff.mx;
         sqy_ff <= a_ff.my * a_ff.my;
         c_ff   <= b_ff;
         s_ff   <= sqx_ff + sqy_ff;
      end
   end

   // square root, one root bit per stage
   logic [SQ-1:0] rt_ff [SQ];
   logic [RW-1:0] rm_ff [SQ];
   logic [SW-1:0] sv_ff [SQ];
   pay_type       sp_ff [SQ];
   logic          sq_valid_ff [SQ];

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      logic [SQ-1:0] rt_prev;
      logic [RW-1:0] rm_prev;
      logic [SW-1:0] sv_prev;
      pay_type       p_prev;
      logic          v_prev;
      logic [RW-1:0] rem_t, trial;
      logic          ge;
      if (k == 0) begin : g_first
         assign rt_prev = '0;
         assign rm_prev = '0;
         assign sv_prev = s_ff;
         assign p_prev  = c_ff;
         assign v_prev  = c_valid_ff;
      end else begin : g_next
         assign rt_prev = rt_ff[k-1];
         assign rm_prev = rm_ff[k-1];
         assign sv_prev = sv_ff[k-1];
         assign p_prev  = sp_ff[k-1];
         assign v_prev  = sq_valid_ff[k-1];
      end
      always_comb begin
         rem_t = {rm_prev[RW-3:0], sv_prev[SW-1 -: 2]};
         trial = {1'b0, rt_prev, 2'b01};
         ge    = rem_t >= trial;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[k] <= v_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rm_ff[k] <= ge ? rem_t - trial : rem_t;
            rt_ff[k] <= {rt_prev[SQ-2:0], ge};
            sv_ff[k] <= sv_prev << 2;
            sp_ff[k] <= p_prev;
         end
      end
   end

   // correction numerators
   logic [SQ-1:0]       root;
   logic signed [W+1:0] delta;
   logic [W+1:0]        mdel;
   logic [NW-1:0]       numx_in, numy_in, numx_ff, numy_ff;
   logic [DW-1:0]       den_ff;
   logic                sx_ff, sy_ff, zero_ff, d_valid_ff;
   pay_type             d_ff;

   always_comb begin
      root    = rt_ff[SQ-1];
      delta   = $signed({3'b000, sp_ff[SQ-1].rest}) - $signed({1'b0, root});
      mdel    = delta[W+1] ? (W+2)'(0) - delta : delta;
      numx_in = NW'(sp_ff[SQ-1].mx * mdel) + NW'(root);
      numy_in = NW'(sp_ff[SQ-1].my * mdel) + NW'(root);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= sq_valid_ff[SQ-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff <= numx_in;
         numy_ff <= numy_in;
         den_ff  <= {root, 1'b0};
         sx_ff   <= sp_ff[SQ-1].nx ^ delta[W+1];
         sy_ff   <= sp_ff[SQ-1].ny ^ delta[W+1];
         zero_ff <= root == '0;
         d_ff    <= sp_ff[SQ-1];
      end
   end

   // long division, one quotient bit per stage for both axes
   logic [QW-1:0] qx_ff [QW];
   logic [QW-1:0] qy_ff [QW];
   logic [DW-1:0] rx_ff [QW];
   logic [DW-1:0] ry_ff [QW];
   logic [QW-1:0] nx_ff [QW];
   logic [QW-1:0] ny_ff [QW];
   logic [DW-1:0] dv_ff [QW];
   logic          dsx_ff [QW];
   logic          dsy_ff [QW];
   logic          dz_ff [QW];
   pay_type       dp_ff [QW];
   logic          dv_valid_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [QW-1:0] qx_p, qy_p, nx_p, ny_p;
      logic [DW-1:0] rx_p, ry_p, den_p;
      logic          sx_p, sy_p, z_p, v_p;
      pay_type       p_p;
      logic [DW:0]   tx, ty;
      logic          gx, gy;
      if (j == 0) begin : g_first
         assign qx_p  = '0;
         assign qy_p  = '0;
         assign rx_p  = numx_ff[NW-1 -: DW];
         assign ry_p  = numy_ff[NW-1 -: DW];
         assign nx_p  = numx_ff[QW-1:0];
         assign ny_p  = numy_ff[QW-1:0];
         assign den_p = den_ff;
         assign sx_p  = sx_ff;
         assign sy_p  = sy_ff;
         assign z_p   = zero_ff;
         assign p_p   = d_ff;
         assign v_p   = d_valid_ff;
      end else begin : g_next
         assign qx_p  = qx_ff[j-1];
         assign qy_p  = qy_ff[j-1];
         assign rx_p  = rx_ff[j-1];
         assign ry_p  = ry_ff[j-1];
         assign nx_p  = nx_ff[j-1];
         assign ny_p  = ny_ff[j-1];
         assign den_p = dv_ff[j-1];
         assign sx_p  = dsx_ff[j-1];
         assign sy_p  = dsy_ff[j-1];
         assign z_p   = dz_ff[j-1];
         assign p_p   = dp_ff[j-1];
         assign v_p   = dv_valid_ff[j-1];
      end
      always_comb begin
         tx = {rx_p, nx_p[QW-1]};
         ty = {ry_p, ny_p[QW-1]};
         gx = tx >= {1'b0, den_p};
         gy = ty >= {1'b0, den_p};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j] <= v_p;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[j]  <= gx ? DW'(tx - {1'b0, den_p}) : DW'(tx);
            ry_ff[j]  <= gy ? DW'(ty - {1'b0, den_p}) : DW'(ty);
            qx_ff[j]  <= {qx_p[QW-2:0], gx};
            qy_ff[j]  <= {qy_p[QW-2:0], gy};
            nx_ff[j]  <= nx_p << 1;
            ny_ff[j]  <= ny_p << 1;
            dv_ff[j]  <= den_p;
            dsx_ff[j] <= sx_p;
            dsy_ff[j] <= sy_p;
            dz_ff[j]  <= z_p;
            dp_ff[j]  <= p_p;
         end
      end
   end

   // apply offsets, saturate
   localparam logic signed [EW-1:0] CMAX = EW'((64'sd1 <<< (W-1)) - 64'sd1);
   localparam logic signed [EW-1:0] CMIN = -CMAX - EW'(1);

   function automatic logic signed [W-1:0] sat(input logic signed [EW-1:0] v);
      logic signed [W-1:0] r;
      if (v > CMAX) begin
         r = CMAX[W-1:0];
      end else if (v < CMIN) begin
         r = CMIN[W-1:0];
      end else begin
         r = v[W-1:0];
      end
      return r;
   endfunction

   pay_type              e;
   logic signed [EW-1:0] ox, oy;
   logic                 apply;
   logic signed [W-1:0]  fx_in, fy_in, gx_in, gy_in;
   logic                 flag_in;

   always_comb begin
      e       = dp_ff[QW-1];
      ox      = dsx_ff[QW-1] ? -$signed({2'b00, qx_ff[QW-1]}) : $signed({2'b00, qx_ff[QW-1]});
      oy      = dsy_ff[QW-1] ? -$signed({2'b00, qy_ff[QW-1]}) : $signed({2'b00, qy_ff[QW-1]});
      apply   = e.act && !dz_ff[QW-1];
      flag_in = e.act && dz_ff[QW-1];
      fx_in   = apply ? sat(EW'(e.x1) + ox) : e.x1;
      fy_in   = apply ? sat(EW'(e.y1) + oy) : e.y1;
      gx_in   = apply ? sat(EW'(e.x2) - ox) : e.x2;
      gy_in   = apply ? sat(EW'(e.y2) - oy) : e.y2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (en) begin
         rsp_valid <= dv_valid_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_new_first_x  <= fx_in;
         rsp_new_first_y  <= fy_in;
         rsp_new_second_x <= gx_in;
         rsp_new_second_y <= gy_in;
         rsp_coincident   <= flag_in;
      end
   end

   a_coincident_same : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coincident |->
         rsp_new_first_x == rsp_new_second_x && rsp_new_first_y == rsp_new_second_y)
      else $error("coincident result with distinct points");

   a_div_rem : assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[QW-1] && !dz_ff[QW-1] |->
         rx_ff[QW-1] < dv_ff[QW-1] && ry_ff[QW-1] < dv_ff[QW-1])
      else $error("division remainder not below divisor");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire

>>> dv/tb_distance_constraint_projection.sv
`timescale 1ns / 1ps
module tb_distance_constraint_projection import dcp_pkg::*;;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int LATENCY = 2 * CW + 8;
   localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint CMIN = -CMAX - 1;

   typedef struct {
      logic signed [CW-1:0] x1, y1, x2, y2;
      logic [CW-2:0]        rest;
      logic                 act;
   } constraint_type;

   typedef struct {
      logic signed [CW-1:0] fx, fy, sx, sy;
      logic                 co;
   } projection_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [CW-1:0] req_first_x = 0, req_first_y = 0;
   logic signed [CW-1:0] req_second_x = 0, req_second_y = 0;
   logic [CW-2:0] req_rest_length = 0;
   logic req_active = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [CW-1:0] rsp_new_first_x, rsp_new_first_y;
   logic signed [CW-1:0] rsp_new_second_x, rsp_new_second_y;
   logic rsp_coincident;

   distance_constraint_projection #(.COORD_WIDTH(CW)) uut (.*);

   projection_type pending_projections[$];
   int mismatches = 0;
   int results_seen = 0;
   int requests_sent = 0;
   int coincident_seen = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [127:0] magnitude(longint v);
      return v < 0 ? 128'(-v) : 128'(v);
   endfunction

   function automatic longint clamp(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
   endfunction

   function automatic longint axis_offset(longint d, longint delta, logic [127:0] root);
      logic [127:0] num, m;
      num = magnitude(d) * magnitude(delta) + root;
      m = num / (root << 1);
      return ((d < 0) != (delta < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic projection_type project(constraint_type c);
      projection_type r;
      longint dx, dy, delta, ox, oy;
      logic [127:0] sq, root, cand;
      r.fx = c.x1; r.fy = c.y1; r.sx = c.x2; r.sy = c.y2; r.co = 0;
      if (c.act) begin
         dx = longint'(c.x1) - longint'(c.x2);
         dy = longint'(c.y1) - longint'(c.y2);
         sq = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy);
         root = 0;
         for (int b = CW + 1; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sq) root = cand;
         end
         if (root == 0) begin
            r.co = 1;
         end else begin
            delta = longint'(c.rest) - longint'(root);
            ox = axis_offset(dx, delta, root);
            oy = axis_offset(dy, delta, root);
            r.fx = CW'(clamp(longint'(c.x1) + ox));
            r.fy = CW'(clamp(longint'(c.y1) + oy));
            r.sx = CW'(clamp(longint'(c.x2) - ox));
            r.sy = CW'(clamp(longint'(c.y2) - oy));
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      constraint_type c;
      if (!reset && req_valid && !req_stall) begin
         c.x1 = req_first_x; c.y1 = req_first_y;
         c.x2 = req_second_x; c.y2 = req_second_y;
         c.rest = req_rest_length; c.act = req_active;
         pending_projections.push_back(project(c));
         requests_sent++;
      end
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      projection_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_projections.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at %0t", $time);
         end else begin
            e = pending_projections.pop_front();
            if (rsp_coincident) coincident_seen++;
            if (rsp_new_first_x !== e.fx || rsp_new_first_y !== e.fy ||
                rsp_new_second_x !== e.sx || rsp_new_second_y !== e.sy ||
                rsp_coincident !== e.co) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch %0t: exp %0d %0d %0d %0d c%0b got %0d %0d %0d %0d c%0b",
                           $time, e.fx, e.fy, e.sx, e.sy, e.co, rsp_new_first_x,
                           rsp_new_first_y, rsp_new_second_x, rsp_new_second_y,
                           rsp_coincident);
            end
         end
      end
   end

   task automatic send_constraint(constraint_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_first_x <= c.x1; req_first_y <= c.y1;
      req_second_x <= c.x2; req_second_y <= c.y2;
      req_rest_length <= c.rest; req_active <= c.act;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_projections.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int mode);
      case (mode)
         0: return CW'($signed($urandom_range(2097151)) - 1048576);
         1: return CW'($urandom);
         2: return $urandom_range(1) ? CW'(CMAX - $urandom_range(65535))
                                     : CW'(CMIN + $urandom_range(65535));
         default: return CW'($signed($urandom_range(255)) - 128);
      endcase
   endfunction

   function automatic constraint_type rand_constraint();
      constraint_type c;
      int mode;
      mode = $urandom_range(3);
      c.x1 = rand_coord(mode); c.y1 = rand_coord(mode);
      c.x2 = rand_coord($urandom_range(3) == 0 ? $urandom_range(3) : mode);
      c.y2 = rand_coord(mode);
      if ($urandom_range(19) == 0) begin
         c.x2 = c.x1; c.y2 = c.y1;
      end
      case ($urandom_range(3))
         0: c.rest = (CW-1)'($urandom);
         1: c.rest = (CW-1)'($urandom_range(2097151));
         2: c.rest = $urandom_range(1) ? '1 : '0;
         default: c.rest = (CW-1)'($urandom_range(1023));
      endcase
      c.act = ($urandom_range(9) != 0);
      return c;
   endfunction

   function automatic constraint_type mk(longint x1, longint y1, longint x2, longint y2,
                                         longint rest, logic act);
      constraint_type c;
      c.x1 = CW'(x1); c.y1 = CW'(y1); c.x2 = CW'(x2); c.y2 = CW'(y2);
      c.rest = (CW-1)'(rest); c.act = act;
      return c;
   endfunction

   task automatic test_directed();
      send_constraint(mk(1 << 16, 2 << 16, 3 << 16, 4 << 16, 1 << 16, 0));
      send_constraint(mk(CMAX, CMIN, CMIN, CMAX, CMAX, 0));
      send_constraint(mk(5 << 16, 5 << 16, 5 << 16, 5 << 16, 1 << 16, 1));
      send_constraint(mk(CMIN, CMIN, CMIN, CMIN, CMAX, 1));
      send_constraint(mk(CMAX, CMAX, CMAX, CMAX, 0, 1));
      send_constraint(mk(0, 0, 3 << 16, 4 << 16, 5 << 16, 1));
      send_constraint(mk(0, 0, 3 << 16, 4 << 16, 10 << 16, 1));
      send_constraint(mk(0, 0, 3 << 16, 4 << 16, 0, 1));
      send_constraint(mk(CMAX, CMAX, CMIN, CMIN, 0, 1));
      send_constraint(mk(CMAX, CMAX, CMIN, CMIN, CMAX, 1));
      send_constraint(mk(CMAX, 0, CMAX - 1, 0, CMAX, 1));
      send_constraint(mk(CMIN, 0, CMIN + 1, 0, CMAX, 1));
      send_constraint(mk(CMAX, CMIN, CMIN, CMAX, CMAX, 1));
      send_constraint(mk(1, 0, 0, 0, 0, 1));
      send_constraint(mk(1, 0, 0, 0, 2, 1));
      send_constraint(mk(0, 1, 0, 0, 4, 1));
      send_constraint(mk(-1, -1, 1, 1, 1, 1));
      send_constraint(mk(0, 0, 0, 0, 0, 1));
      send_constraint(mk(0, 0, 0, 0, 0, 0));
      send_constraint(mk(12345, -6789, -12345, 6789, CMAX, 1));
      wait_drain();
   endtask

   task automatic test_random(int count, int idle, int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_constraint(rand_constraint());
      wait_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 400;
      repeat (200) send_constraint(rand_constraint());
      wait_drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(280, 0, 0);
      test_random(280, 84, 0);
      test_random(280, 0, 84);
      test_random(280, 16, 16);
      test_backpressure();
      stall_pct = 0;
      repeat (LATENCY + 20) @(posedge clock);
      if (pending_projections.size() != 0) mismatches++;
      $display("%0d constraints sent, %0d results checked, %0d coincident", requests_sent,
               results_seen, coincident_seen);
      $display("covered extremes, saturation, inactive, stalls and a long output hold");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/dcp_pkg.sv
rtl/distance_constraint_projection.sv
dv/tb_distance_constraint_projection.sv
